FILE: rtl/lrupr_pkg.sv
// lrupr_pkg: shared types and constants for the lru page replacement block
// no dependencies; imported by the controller, the datapath and the top level
package lrupr_pkg;

    localparam int CFG_BITS = 4;
    localparam logic [CFG_BITS-1:0] FRAMES_USED_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } lrupr_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } lrupr_cmd_t;

endpackage

FILE: rtl/lrupr_if.sv
// lrupr_req_if / lrupr_rsp_if: valid/ready channels for page requests and results
// no dependencies
interface lrupr_req_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_of_string;

    modport source (output valid, output page_number, output last_of_string, input ready);
    modport sink   (input valid, input page_number, input last_of_string, output ready);
endinterface

interface lrupr_rsp_if #(
    parameter int PAGE_BITS  = 16,
    parameter int IDX_BITS   = 3,
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [IDX_BITS-1:0]   frame_index;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] hit_count;

    modport source (
        output valid, output hit, output frame_index, output evicted_valid,
        output evicted_page, output hit_count, input ready
    );
    modport sink (
        input valid, input hit, input frame_index, input evicted_valid,
        input evicted_page, input hit_count, output ready
    );
endinterface

FILE: rtl/lrupr_ctrl.sv
// lrupr_ctrl: request sequencer and result valid flag
// depends on lrupr_pkg
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output lrupr_cmd_t cmd
);

    lrupr_state_t state_reg, state_next;
    logic         out_valid_reg, out_valid_next;

    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        cmd.capture = req_ready && req_valid;
        cmd.commit  = (state_reg == ST_LOOKUP) && (!out_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/lrupr_datapath.sv
// lrupr_datapath: frame table, recency ranks, hit counter and result register
// depends on lrupr_pkg
module lrupr_datapath
    import lrupr_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_wdata,
    input  lrupr_cmd_t            cmd,
    input  logic [PAGE_BITS-1:0]  in_page,
    input  logic                  in_last,
    output logic                  out_hit,
    output logic [IDX_BITS-1:0]   out_frame,
    output logic                  out_ev_valid,
    output logic [PAGE_BITS-1:0]  out_ev_page,
    output logic [COUNT_BITS-1:0] out_count
);

    localparam int CNT_BITS  = $clog2(FRAMES + 1);
    localparam int RANK_BITS = IDX_BITS;

    logic [CFG_BITS-1:0]   frames_used_reg;
    logic [PAGE_BITS-1:0]  req_page_reg;
    logic                  req_last_reg;
    logic [PAGE_BITS-1:0]  page_reg [FRAMES];
    logic [FRAMES-1:0]     valid_reg;
    logic [RANK_BITS-1:0]  rank_reg [FRAMES];
    logic [COUNT_BITS-1:0] count_reg;

    logic                  hit_reg;
    logic [IDX_BITS-1:0]   frame_reg;
    logic                  ev_valid_reg;
    logic [PAGE_BITS-1:0]  ev_page_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;

    logic [CNT_BITS-1:0]   active_cnt;
    logic [FRAMES-1:0]     in_act;
    logic                  any_hit;
    logic                  any_empty;
    logic [IDX_BITS-1:0]   hit_idx;
    logic [IDX_BITS-1:0]   empty_idx;
    logic [IDX_BITS-1:0]   vic_idx;
    logic [RANK_BITS-1:0]  vic_rank;
    logic [IDX_BITS-1:0]   sel_idx;
    logic [RANK_BITS-1:0]  old_rank;
    logic                  age_all;
    logic [RANK_BITS-1:0]  rank_next [FRAMES];
    logic [FRAMES-1:0]     valid_next;
    logic [COUNT_BITS-1:0] count_next;

    // clamp frames in use to 1..FRAMES
    always_comb
    begin
        if (frames_used_reg == '0)
        begin
            active_cnt = CNT_BITS'(1);
        end
        else if (32'(frames_used_reg) > 32'(FRAMES))
        begin
            active_cnt = CNT_BITS'(FRAMES);
        end
        else
        begin
            active_cnt = CNT_BITS'(frames_used_reg);
        end
    end

    // lowest matching frame and lowest empty frame
    always_comb
    begin
        any_hit   = 1'b0;
        any_empty = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            in_act[i] = CNT_BITS'(i) < active_cnt;
            if (in_act[i] && valid_reg[i] && (page_reg[i] == req_page_reg))
            begin
                any_hit = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
            if (in_act[i] && !valid_reg[i])
            begin
                any_empty = 1'b1;
                empty_idx = IDX_BITS'(i);
            end
        end
    end

    // least recently used frame in use, lowest index on a tie
    always_comb
    begin
        vic_idx  = '0;
        vic_rank = rank_reg[0];
        for (int i = 1; i < FRAMES; i++)
        begin
            if (in_act[i] && (rank_reg[i] > vic_rank))
            begin
                vic_idx  = IDX_BITS'(i);
                vic_rank = rank_reg[i];
            end
        end
    end

    always_comb
    begin
        if (any_hit)
        begin
            sel_idx = hit_idx;
        end
        else if (any_empty)
        begin
            sel_idx = empty_idx;
        end
        else
        begin
            sel_idx = vic_idx;
        end
        old_rank = rank_reg[sel_idx];
        age_all  = !any_hit && any_empty;
        for (int i = 0; i < FRAMES; i++)
        begin
            valid_next[i] = valid_reg[i] || (IDX_BITS'(i) == sel_idx);
            if (IDX_BITS'(i) == sel_idx)
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (age_all || (rank_reg[i] < old_rank)))
            begin
                rank_next[i] = rank_reg[i] + RANK_BITS'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
        if (any_hit && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_used_reg <= FRAMES_USED_RESET;
            valid_reg       <= '0;
            count_reg       <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                frames_used_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                if (req_last_reg)
                begin
                    valid_reg <= '0;
                    count_reg <= '0;
                    for (int i = 0; i < FRAMES; i++)
                    begin
                        rank_reg[i] <= '0;
                    end
                end
                else
                begin
                    valid_reg <= valid_next;
                    count_reg <= count_next;
                    for (int i = 0; i < FRAMES; i++)
                    begin
                        rank_reg[i] <= rank_next[i];
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_page_reg <= in_page;
            req_last_reg <= in_last;
        end
        if (cmd.commit)
        begin
            page_reg[sel_idx] <= req_page_reg;
            hit_reg           <= any_hit;
            frame_reg         <= sel_idx;
            ev_valid_reg      <= !any_hit && !any_empty;
            ev_page_reg       <= (!any_hit && !any_empty) ? page_reg[vic_idx] : '0;
            hit_count_reg     <= count_next;
        end
    end

    assign out_hit      = hit_reg;
    assign out_frame    = frame_reg;
    assign out_ev_valid = ev_valid_reg;
    assign out_ev_page  = ev_page_reg;
    assign out_count    = hit_count_reg;

endmodule

FILE: rtl/lru_page_replacement_top.sv
// lru_page_replacement_top: lru page replacement unit, controller plus datapath
// depends on lrupr_pkg, lrupr_if, lrupr_ctrl, lrupr_datapath
//
//   channel  dir  signals                                   transfer
//   req      in   page_number, last_of_string               valid & ready
//   rsp      out  hit, frame_index, evicted_valid,          valid & ready
//                 evicted_page, hit_count
//   cfg      in   cfg_we, cfg_wdata (frames_used)           cfg_we
//
// each request passes through capture, then a lookup state that compares all
// frames in parallel, updates the ranks and loads the result register
// the lookup state waits while the result register still holds an untaken result
// reset clears all frames, the ranks and the hit counter; frames_used resets to 8
// a request marked last_of_string clears frames and counter once it commits
module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_wdata,
    lrupr_req_if.sink             req,
    lrupr_rsp_if.source           rsp
);

    localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    lrupr_cmd_t cmd;
    logic       req_ready;
    logic       rsp_valid;

    lrupr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    lrupr_datapath #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .in_page      (req.page_number),
        .in_last      (req.last_of_string),
        .out_hit      (rsp.hit),
        .out_frame    (rsp.frame_index),
        .out_ev_valid (rsp.evicted_valid),
        .out_ev_page  (rsp.evicted_page),
        .out_count    (rsp.hit_count)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

FILE: bench/lru_page_replacement_top_tb.sv
// lru_page_replacement_top_tb: self-checking bench for the lru page replacement unit
// tracks frames, recency ranks and the hit counter, and checks every result in order
// depends on lrupr_pkg, lrupr_if and lru_page_replacement_top
typedef struct packed {
    logic        hit;
    logic [2:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [15:0] hit_count;
} lru_result_t;

class lru_result_board;
    localparam int NUM_FRAMES = 8;

    logic [15:0] frame_page [NUM_FRAMES];
    bit          frame_valid [NUM_FRAMES];
    logic [2:0]  recency_rank [NUM_FRAMES];
    logic [15:0] hit_counter;
    logic [3:0]  frames_used;
    lru_result_t expected_q [$];
    int          error_count;

    function new();
        clear_frames();
        frames_used = lrupr_pkg::FRAMES_USED_RESET;
        error_count = 0;
    endfunction

    function void clear_frames();
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            frame_page[i]   = '0;
            frame_valid[i]  = 1'b0;
            recency_rank[i] = '0;
        end
        hit_counter = '0;
    endfunction

    function void set_frames_used(logic [3:0] value);
        frames_used = value;
    endfunction

    function int pending_count();
        return expected_q.size();
    endfunction

    // frame f becomes most recent, frames newer than its old rank age by one
    function void make_recent(int f, int old_rank);
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (frame_valid[i] && i != f && int'(recency_rank[i]) < old_rank)
                recency_rank[i] = recency_rank[i] + 3'd1;
        end
        recency_rank[f] = '0;
    endfunction

    function void note_request(logic [15:0] page, logic last);
        int          active;
        int          f;
        int          worst;
        bit          hit_found;
        bit          empty_found;
        lru_result_t want;
        want        = '0;
        hit_found   = 1'b0;
        empty_found = 1'b0;
        f           = 0;
        active      = int'(frames_used);
        if (active == 0)
            active = 1;
        if (active > NUM_FRAMES)
            active = NUM_FRAMES;
        for (int i = 0; i < active; i++)
        begin
            if (!hit_found && frame_valid[i] && frame_page[i] == page)
            begin
                hit_found = 1'b1;
                f = i;
            end
        end
        if (hit_found)
        begin
            make_recent(f, int'(recency_rank[f]));
            if (hit_counter != 16'hFFFF)
                hit_counter = hit_counter + 16'd1;
        end
        else
        begin
            for (int i = 0; i < active; i++)
            begin
                if (!empty_found && !frame_valid[i])
                begin
                    empty_found = 1'b1;
                    f = i;
                end
            end
            if (empty_found)
            begin
                frame_valid[f] = 1'b1;
                frame_page[f]  = page;
                make_recent(f, NUM_FRAMES + 1);
            end
            else
            begin
                worst = -1;
                for (int i = 0; i < active; i++)
                begin
                    if (int'(recency_rank[i]) > worst)
                    begin
                        worst = int'(recency_rank[i]);
                        f = i;
                    end
                end
                want.evicted_valid = 1'b1;
                want.evicted_page  = frame_page[f];
                frame_page[f]      = page;
                make_recent(f, int'(recency_rank[f]));
            end
        end
        want.hit         = hit_found;
        want.frame_index = 3'(f);
        want.hit_count   = hit_counter;
        expected_q.push_back(want);
        if (last)
            clear_frames();
    endfunction

    function void report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endfunction

    function void check_result(lru_result_t got);
        lru_result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("result transfer with nothing pending");
            return;
        end
        want = expected_q.pop_front();
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit got %0h want %0h", got.hit, want.hit));
        if (got.frame_index !== want.frame_index)
            report_mismatch($sformatf("frame_index got %0h want %0h",
                got.frame_index, want.frame_index));
        if (got.evicted_valid !== want.evicted_valid)
            report_mismatch($sformatf("evicted_valid got %0h want %0h",
                got.evicted_valid, want.evicted_valid));
        if (got.evicted_page !== want.evicted_page)
            report_mismatch($sformatf("evicted_page got %0h want %0h",
                got.evicted_page, want.evicted_page));
        if (got.hit_count !== want.hit_count)
            report_mismatch($sformatf("hit_count got %0h want %0h",
                got.hit_count, want.hit_count));
    endfunction
endclass

module lru_page_replacement_top_tb
    import lrupr_pkg::*;
();

    localparam int RUN_LIMIT    = 1_200_000;
    localparam int RANDOM_ITEMS = 590;
    localparam int FAST_HITS    = 40;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_wdata;

    lrupr_req_if req_ch ();
    lrupr_rsp_if rsp_ch ();

    lru_result_board board;
    int              cycle_count;
    int              items_sent;
    int              burst_left;
    bit              rsp_fast;

    lru_page_replacement_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // receiver stall pattern, switching between steady, random and long stalls
    initial
    begin : rsp_stall
        int stall_left;
        int mode_left;
        int rsp_mode;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        mode_left    = 0;
        rsp_mode     = 0;
        forever
        begin
            @(negedge clk);
            if (rsp_fast)
                rsp_ch.ready = 1'b1;
            else
            begin
                if (mode_left == 0)
                begin
                    rsp_mode  = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                if (stall_left > 0)
                begin
                    rsp_ch.ready = 1'b0;
                    stall_left--;
                end
                else
                begin
                    case (rsp_mode)
                        0: rsp_ch.ready = 1'b1;
                        1: rsp_ch.ready = 1'($urandom_range(0, 1));
                        default:
                        begin
                            if ($urandom_range(0, 3) == 0)
                            begin
                                rsp_ch.ready = 1'b0;
                                stall_left   = $urandom_range(1, 7);
                            end
                            else
                                rsp_ch.ready = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        lru_result_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.hit           = rsp_ch.hit;
            seen.frame_index   = rsp_ch.frame_index;
            seen.evicted_valid = rsp_ch.evicted_valid;
            seen.evicted_page  = rsp_ch.evicted_page;
            seen.hit_count     = rsp_ch.hit_count;
            board.check_result(seen);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input logic [15:0] page, input logic last);
        req_ch.valid          = 1'b1;
        req_ch.page_number    = page;
        req_ch.last_of_string = last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(page, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        req_ch.valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic send_paced(input logic [15:0] page, input logic last);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_request(page, last);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (board.pending_count() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_frames_used(input logic [3:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        board.set_frames_used(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // working set around a random base, with repeats and some far pages
    task automatic run_string(input int length, input bit close);
        logic [15:0] base;
        logic [15:0] page;
        logic [15:0] recent;
        int          span;
        base   = 16'($urandom);
        span   = $urandom_range(1, 12);
        recent = base;
        for (int k = 0; k < length; k++)
        begin
            case ($urandom_range(0, 9))
                0:       page = 16'($urandom);
                1, 2, 3: page = recent;
                default: page = base ^ 16'($urandom_range(0, span - 1));
            endcase
            recent = page;
            send_paced(page, close && (k == length - 1));
        end
    endtask

    initial
    begin
        int len;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        req_ch.valid          = 1'b0;
        req_ch.page_number    = '0;
        req_ch.last_of_string = 1'b0;
        rsp_fast              = 1'b0;
        burst_left            = 0;
        items_sent            = 0;
        board                 = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill all eight frames, hit, then evict the oldest
        write_frames_used(4'd8);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        for (int k = 1; k <= 6; k++)
            send_request(16'(k), 1'b0);
        send_request(16'h8000, 1'b0);
        send_request(16'hFFFF, 1'b1);

        // zero frames behaves as one frame
        write_frames_used(4'd0);
        send_request(16'h1234, 1'b0);
        send_request(16'h1234, 1'b0);
        send_request(16'h4321, 1'b1);

        // above the built count saturates, then shrink and regrow mid-string
        write_frames_used(4'd15);
        for (int k = 0; k < 8; k++)
            send_request(16'h0200 + 16'(k), 1'b0);
        write_frames_used(4'd2);
        send_request(16'h0205, 1'b0);
        write_frames_used(4'd8);
        send_request(16'h0205, 1'b1);

        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_frames_used(4'($urandom_range(0, 15)));
            len = $urandom_range(1, 48);
            if ($urandom_range(0, 5) == 0)
            begin
                run_string(len, 1'b0);
                write_frames_used(4'($urandom_range(0, 15)));
                run_string($urandom_range(1, 24), 1'b1);
            end
            else
                run_string(len, 1'b1);
        end

        // back-to-back requests for one page, hits after the first, with the receiver always ready
        write_frames_used(4'd8);
        rsp_fast = 1'b1;
        for (int k = 0; k < FAST_HITS; k++)
            send_request(16'hA5A5, 1'b0);
        send_request(16'hA5A5, 1'b1);
        wait_drained();
        rsp_fast = 1'b0;

        write_frames_used(4'd1);
        run_string(12, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.error_count == 0 && board.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
rtl/lrupr_pkg.sv
rtl/lrupr_if.sv
rtl/lrupr_ctrl.sv
rtl/lrupr_datapath.sv
rtl/lru_page_replacement_top.sv
bench/lru_page_replacement_top_tb.sv
